// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define DT_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition must never be seen outside reset
`define DT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define DT_ASSERT(name, clk, rst, prop)
`define DT_NEVER(name, clk, rst, cond)

`endif

`endif

// File: sv/dnsttl_pkg.sv
// ----------------------------------------------------------------------------
// dnsttl_pkg
// types, constants and helper functions of the record ttl scanner
// ----------------------------------------------------------------------------
`default_nettype none

package dnsttl_pkg;

   localparam int unsigned HDR_LEN  = 12;
   localparam int unsigned HDR_KEEP = 4;   // header bytes from here on are kept
   localparam logic [15:0] Q_FIXED  = 16'd4;
   localparam logic [15:0] RR_FIXED = 16'd10;
   localparam logic [15:0] OPT_TYPE = 16'd41;
   localparam logic [7:0]  PTR_MASK = 8'hc0;
   localparam logic [9:0]  CNT_MAX  = 10'd1023;

   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALL_SECTIONS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REWRITE      = 2'd1;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_NAME,
      PH_LABEL,
      PH_PTR,
      PH_FIXED,
      PH_RDATA,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic all_sections;
      logic rewrite_enable;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_last;
      logic        well_formed;
      logic [31:0] min_ttl;
      logic [9:0]  ttl_count;
      logic        cacheable;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  sect;
      logic [15:0] recs;
      phase_type   phase;
   } entry_type;

   // entry count of a section from the kept header words
   function automatic logic [15:0] section_count(input logic [63:0] hdr,
                                                 input logic [1:0] idx);
      logic [15:0] cnt;
      case (idx)
         2'd0:    cnt = hdr[63:48];
         2'd1:    cnt = hdr[47:32];
         2'd2:    cnt = hdr[31:16];
         default: cnt = hdr[15:0];
      endcase
      return cnt;
   endfunction

   // skip empty sections; at most four section checks
   function automatic entry_type next_entry(input logic [1:0]  sect,
                                            input logic [15:0] recs,
                                            input logic [63:0] hdr,
                                            input logic        all_sec);
      entry_type  e;
      logic [1:0] limit;
      e.sect  = sect;
      e.recs  = recs;
      e.phase = PH_NAME;
      limit   = all_sec ? 2'd3 : 2'd1;
      for (int i = 0; i < 4; i++) begin
         if (e.recs == 16'd0 && e.phase == PH_NAME) begin
            if (e.sect >= limit) begin
               e.phase = PH_DONE;
            end else begin
               e.sect = e.sect + 2'd1;
               e.recs = section_count(hdr, e.sect);
            end
         end
      end
      return e;
   endfunction

endpackage

`default_nettype wire

// File: sv/dns_record_ttl_scanner_top.sv
// ----------------------------------------------------------------------------
// dns_record_ttl_scanner_top
// byte-wide dns message walker that echoes bytes, optionally rewriting record ttls, and summarises record ttls
// ----------------------------------------------------------------------------
//   port group | direction | handshake           | carries
//   req_*      | in        | req_valid/req_stall | data_byte, last_byte, new_ttl
//   rsp_*      | out       | rsp_valid/rsp_stall | echoed byte and message summary
//   csr_*      | in        | csr_valid/csr_ready | register index and write bit
//
// one byte per cycle sustained while rsp_stall is low; a byte is first held in the input
// register and its result is then offered from the result register.
// the walker updates as a byte moves from the input register to the result register.
// reset is synchronous and clears the config registers and all message state.
// a held result stalls the input side in the same cycle only when both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_record_ttl_scanner_top #(
   parameter int unsigned MAX_MESSAGE_BYTES = 4096
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [7:0]                        req_data_byte,
   input  wire                               req_last_byte,
   input  wire  [31:0]                       req_new_ttl,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_out_last,
   output logic                              rsp_well_formed,
   output logic [31:0]                       rsp_min_ttl,
   output logic [9:0]                        rsp_ttl_count,
   output logic                              rsp_cacheable,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [dnsttl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire                               csr_wdata
);
   import dnsttl_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic [31:0] in_ttl_ff;
   logic        out_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;
   cfg_type     cfg;
   logic        out_adv;
   logic        step;

   assign out_adv   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_adv;
   assign req_stall = in_valid_ff && !out_adv;

   dnsttl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dnsttl_parse #(
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .item_byte    (in_byte_ff),
      .item_last    (in_last_ff),
      .item_new_ttl (in_ttl_ff),
      .cfg          (cfg),
      .rsp          (rsp_in)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
         in_ttl_ff  <= req_new_ttl;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_adv) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = rsp_ff.out_byte;
   assign rsp_out_last    = rsp_ff.out_last;
   assign rsp_well_formed = rsp_ff.well_formed;
   assign rsp_min_ttl     = rsp_ff.min_ttl;
   assign rsp_ttl_count   = rsp_ff.ttl_count;
   assign rsp_cacheable   = rsp_ff.cacheable;

endmodule

`default_nettype wire

// File: sv/dnsttl_csr.sv
// ----------------------------------------------------------------------------
// dnsttl_csr
// configuration registers of the scanner, written over the csr channel
// ----------------------------------------------------------------------------
`default_nettype none

module dnsttl_csr (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [dnsttl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire                                  csr_wdata,
   output dnsttl_pkg::cfg_type                  cfg
);
   import dnsttl_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ALL_SECTIONS: cfg_in.all_sections   = csr_wdata;
            CSR_REWRITE:      cfg_in.rewrite_enable = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/dnsttl_parse.sv
// ----------------------------------------------------------------------------
// dnsttl_parse
// message walker: header counts, names, fixed fields, optional ttl rewrite, rdata skip, ttl summary
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dnsttl_parse #(
   parameter int unsigned MAX_MESSAGE_BYTES = 4096
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  step,
   input  wire  [7:0]           item_byte,
   input  wire                  item_last,
   input  wire  [31:0]          item_new_ttl,
   input  dnsttl_pkg::cfg_type  cfg,
   output dnsttl_pkg::rsp_type  rsp
);
   import dnsttl_pkg::*;

   localparam int unsigned OFF_W = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam logic [OFF_W-1:0] OFF_LIMIT    = OFF_W'(MAX_MESSAGE_BYTES);
   localparam logic [OFF_W-1:0] OFF_HDR_KEEP = OFF_W'(HDR_KEEP);
   localparam logic [OFF_W-1:0] OFF_HDR_LAST = OFF_W'(HDR_LEN - 1);

   logic [OFF_W-1:0] off_ff,   off_in;
   phase_type        phase_ff, phase_in;
   logic [63:0]      hdr_ff,   hdr_in;
   logic [15:0]      recs_ff,  recs_in;
   logic [1:0]       sect_ff,  sect_in;
   logic [15:0]      bl_ff,    bl_in;
   logic [15:0]      rtype_ff, rtype_in;
   logic [31:0]      acc_ff,   acc_in;
   logic [31:0]      min_ff,   min_in;
   logic [9:0]       cnt_ff,   cnt_in;
   logic             err_ff,   err_in;

   logic [3:0]       pos;
   logic             rr_fixed;
   logic             counted;
   entry_type        ent;

   // position inside the ten fixed bytes of a resource record
   assign pos      = 4'(RR_FIXED[3:0] - bl_ff[3:0]);
   assign rr_fixed = (phase_ff == PH_FIXED) && (sect_ff != 2'd0);
   assign counted  = rtype_ff != OPT_TYPE;

   always_comb begin : next_state
      off_in   = off_ff;
      phase_in = phase_ff;
      hdr_in   = hdr_ff;
      recs_in  = recs_ff;
      sect_in  = sect_ff;
      bl_in    = bl_ff;
      rtype_in = rtype_ff;
      acc_in   = acc_ff;
      min_in   = min_ff;
      cnt_in   = cnt_ff;
      err_in   = err_ff;
      ent      = next_entry(sect_ff, recs_ff, hdr_ff, cfg.all_sections);
      if (step) begin
         if (off_ff >= OFF_LIMIT) begin
            err_in = 1'b1;
         end else begin
            off_in = off_ff + 1'b1;
         end
         case (phase_ff)
            PH_HEADER: begin
               if (off_ff >= OFF_HDR_KEEP) begin
                  hdr_in = {hdr_ff[55:0], item_byte};
               end
               if (off_ff >= OFF_HDR_LAST) begin
                  ent      = next_entry(2'd0, hdr_in[63:48], hdr_in, cfg.all_sections);
                  sect_in  = ent.sect;
                  recs_in  = ent.recs;
                  phase_in = ent.phase;
               end
            end
            PH_NAME: begin
               if ((item_byte & PTR_MASK) == PTR_MASK) begin
                  phase_in = PH_PTR;
               end else if ((item_byte & PTR_MASK) != 8'd0) begin
                  err_in   = 1'b1;
                  phase_in = PH_DONE;
               end else if (item_byte == 8'd0) begin
                  bl_in    = (sect_ff == 2'd0) ? Q_FIXED : RR_FIXED;
                  phase_in = PH_FIXED;
               end else begin
                  bl_in    = {8'd0, item_byte};
                  phase_in = PH_LABEL;
               end
            end
            PH_LABEL: begin
               bl_in = bl_ff - 16'd1;
               if (bl_in == 16'd0) begin
                  phase_in = PH_NAME;
               end
            end
            PH_PTR: begin
               bl_in    = (sect_ff == 2'd0) ? Q_FIXED : RR_FIXED;
               phase_in = PH_FIXED;
            end
            PH_FIXED: begin
               bl_in = bl_ff - 16'd1;
               if (sect_ff != 2'd0) begin
                  if (pos < 4'd2) begin
                     rtype_in = {rtype_ff[7:0], item_byte};
                  end
                  if (pos >= 4'd4) begin
                     acc_in = {acc_ff[23:0], item_byte};
                  end
                  if (pos == 4'd7 && counted) begin
                     if (cnt_ff < CNT_MAX) begin
                        cnt_in = cnt_ff + 10'd1;
                     end
                     if (acc_in < min_ff) begin
                        min_in = acc_in;
                     end
                  end
               end
               if (bl_in == 16'd0) begin
                  if (sect_ff != 2'd0 && acc_in[15:0] != 16'd0) begin
                     bl_in    = acc_in[15:0];
                     phase_in = PH_RDATA;
                  end else begin
                     ent      = next_entry(sect_ff, recs_ff - 16'd1, hdr_ff,
                                           cfg.all_sections);
                     sect_in  = ent.sect;
                     recs_in  = ent.recs;
                     phase_in = ent.phase;
                  end
               end
            end
            PH_RDATA: begin
               bl_in = bl_ff - 16'd1;
               if (bl_in == 16'd0) begin
                  ent      = next_entry(sect_ff, recs_ff - 16'd1, hdr_ff,
                                        cfg.all_sections);
                  sect_in  = ent.sect;
                  recs_in  = ent.recs;
                  phase_in = ent.phase;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_comb begin : result_out
      logic wf;
      wf           = !err_in && (phase_in == PH_DONE);
      rsp.out_byte = item_byte;
      if (rr_fixed && pos >= 4'd4 && pos <= 4'd7 && counted && cfg.rewrite_enable) begin
         case (pos[1:0])
            2'd0:    rsp.out_byte = item_new_ttl[31:24];
            2'd1:    rsp.out_byte = item_new_ttl[23:16];
            2'd2:    rsp.out_byte = item_new_ttl[15:8];
            default: rsp.out_byte = item_new_ttl[7:0];
         endcase
      end
      rsp.out_last = item_last;
      if (item_last) begin
         rsp.well_formed = wf;
         rsp.min_ttl     = min_in;
         rsp.ttl_count   = cnt_in;
         rsp.cacheable   = wf && (cnt_in != 10'd0) && (min_in != 32'd0);
      end else begin
         rsp.well_formed = 1'b0;
         rsp.min_ttl     = 32'd0;
         rsp.ttl_count   = 10'd0;
         rsp.cacheable   = 1'b0;
      end
   end

   // the last byte of a message clears the walker for the next one
   always_ff @(posedge clock) begin
      if (reset || (step && item_last)) begin
         off_ff   <= '0;
         phase_ff <= PH_HEADER;
         hdr_ff   <= '0;
         recs_ff  <= '0;
         sect_ff  <= '0;
         bl_ff    <= '0;
         rtype_ff <= '0;
         acc_ff   <= '0;
         min_ff   <= '1;
         cnt_ff   <= '0;
         err_ff   <= 1'b0;
      end else if (step) begin
         off_ff   <= off_in;
         phase_ff <= phase_in;
         hdr_ff   <= hdr_in;
         recs_ff  <= recs_in;
         sect_ff  <= sect_in;
         bl_ff    <= bl_in;
         rtype_ff <= rtype_in;
         acc_ff   <= acc_in;
         min_ff   <= min_in;
         cnt_ff   <= cnt_in;
         err_ff   <= err_in;
      end
   end

   `DT_ASSERT(a_clear_after_last, clock, reset,
              step && item_last |=> phase_ff == PH_HEADER && off_ff == '0)
   `DT_NEVER(a_offset_range, clock, reset, off_ff > OFF_LIMIT)
   `DT_ASSERT(a_count_saturates, clock, reset,
              cnt_ff == CNT_MAX && !(step && item_last) |=> cnt_ff == CNT_MAX)
   `DT_NEVER(a_countdown_live, clock, reset,
             (phase_ff == PH_LABEL || phase_ff == PH_FIXED || phase_ff == PH_RDATA)
             && bl_ff == 16'd0)

endmodule

`default_nettype wire
